[design/chp_pkg.sv]
// ----------------------------------------------------------------------------
// chp_pkg - shared types and constants for the convex hull perimeter block
// Output field widths, status codes, datapath micro-ops and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package chp_pkg;

  localparam int PERIM_W     = 42;
  localparam int HULL_W      = 11;
  localparam int STAT_W      = 2;
  localparam int OUT_TDATA_W = ((PERIM_W + HULL_W + 7) / 8) * 8;

  localparam logic [PERIM_W-1:0] PERIM_MAX = '1;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROP = 2'd2;

  typedef enum logic [5:0] {
    OP_NOP,
    OP_STORE,
    OP_CLEAR,
    OP_MIN_RD,
    OP_MIN_CMP,
    OP_RD0,
    OP_SWAP_A,
    OP_SWAP_B,
    OP_RD_I,
    OP_KEY,
    OP_RD_PREV,
    OP_PREV,
    OP_T_DIFF,
    OP_T_M1,
    OP_T_M2,
    OP_T_X,
    OP_D_DIFF_B,
    OP_D_DIFF_C,
    OP_D_M1,
    OP_D_M2,
    OP_D_SUM,
    OP_SHIFT,
    OP_INSERT,
    OP_SCAN_INIT,
    OP_SCAN_GOT,
    OP_SCAN_LD,
    OP_PUSH,
    OP_POP,
    OP_POP_GOT,
    OP_P_INIT,
    OP_P_FIRST,
    OP_P_RD,
    OP_P_GOT,
    OP_P_CLOSE,
    OP_SQ_START,
    OP_ACC
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic few;          // fewer than three points after the current request
    logic min_last;     // lowest-point sweep at last entry
    logic i_end;        // point index reached count
    logic i_lt3;        // first three points of the scan
    logic j_gt1;        // insertion slot above index one
    logic d_gt1;        // stack holds two or more entries
    logic k_eq_d;       // perimeter walk on closing edge
    logic cross_zero;
    logic cross_neg;
    logic dist_before;  // previous point lies farther than key
    logic sq_busy;
  } sts_t;

endpackage

[design/chp_ram.sv]
// ----------------------------------------------------------------------------
// chp_ram - generic single write, single read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module chp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/chp_isqrt.sv]
// ----------------------------------------------------------------------------
// chp_isqrt - bit-serial floor square root
// Restoring digit recurrence, one root bit per cycle.
// ----------------------------------------------------------------------------
module chp_isqrt #(
  parameter int VW = 82
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VW-1:0]     value,
  output logic              busy,
  output logic [VW/2-1:0]   root
);

  localparam int RTW = VW / 2;
  localparam int NW  = $clog2(RTW + 1);

  logic [VW-1:0]  val_r;
  logic [RTW:0]   rem_r;
  logic [RTW-1:0] root_r;
  logic [NW-1:0]  cnt_r;
  logic           busy_r;

  logic [RTW+2:0] rem_t;
  logic [RTW+2:0] trial;
  logic [RTW+2:0] rem_sub;
  logic           fit;

  assign rem_t   = {rem_r, val_r[VW-1:VW-2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign fit     = (rem_t >= trial);
  assign rem_sub = rem_t - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= NW'(RTW);
      val_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= val_r << 2;
      rem_r  <= fit ? rem_sub[RTW:0] : rem_t[RTW:0];
      root_r <= {root_r[RTW-2:0], fit};
      cnt_r  <= cnt_r - NW'(1);
      if (cnt_r == NW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

[design/chp_dp.sv]
// ----------------------------------------------------------------------------
// chp_dp - hull datapath
// Point store, hull stack, shared multiplier, cross/distance registers,
// square root unit and saturating perimeter accumulator.
// ----------------------------------------------------------------------------
module chp_dp #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  chp_pkg::cmd_t                cmd,
  input  logic [COORD_BITS-1:0]        in_x,
  input  logic [COORD_BITS-1:0]        in_y,
  input  logic                         in_last,
  output chp_pkg::sts_t                sts,
  output logic [chp_pkg::PERIM_W-1:0]  perimeter,
  output logic [chp_pkg::HULL_W-1:0]   hull_size,
  output logic [chp_pkg::STAT_W-1:0]   status
);

  import chp_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int PW   = 2 * CB;
  localparam int DFW  = CB + 1;
  localparam int PRW  = 2 * DFW;
  localparam int CRW  = PRW + 1;
  localparam int DW   = PRW;
  localparam int VW   = DW + 2 * FRAC_BITS;
  localparam int RTW  = VW / 2;
  localparam int SUMW = ((RTW > PERIM_W) ? RTW : PERIM_W) + 1;

  function automatic logic signed [DFW-1:0] sub_c(input logic [CB-1:0] a,
                                                  input logic [CB-1:0] b);
    sub_c = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
  endfunction

  logic [CW-1:0] n_r, i_r, j_r, k_r, sd_r;
  logic [AW-1:0] lo_r;
  logic [PW-1:0] pa_r, pb_r, pc_r, t_r, s_r, f_r;
  logic signed [DFW-1:0] ux_r, uy_r, vx_r, vy_r;
  logic signed [PRW-1:0] p1_r, p2_r;
  logic signed [CRW-1:0] cr_r;
  logic [DW-1:0] dd_r, dd0_r;
  logic [PERIM_W-1:0] sum_r;
  logic dropped_r, small_r;

  logic          pt_we, st_we;
  logic [AW-1:0] pt_waddr, pt_raddr, st_waddr, st_raddr;
  logic [PW-1:0] pt_wdata, pt_rdata, st_wdata, st_rdata;

  logic                  has_room, few, lower;
  logic [CW-1:0]         n_nxt, jm1, dm3;
  logic signed [DFW-1:0] mul_a, mul_b;
  logic signed [PRW-1:0] mul_p;
  logic                  sq_start, sq_busy;
  logic [RTW-1:0]        sq_root;
  logic [SUMW-1:0]       sum_ext;

  assign has_room = (n_r < CW'(MAX_POINTS));
  assign n_nxt    = n_r + CW'(has_room);
  assign few      = (n_nxt < CW'(3));
  assign jm1      = j_r - CW'(1);
  assign dm3      = sd_r - CW'(3);
  assign lower    = ($signed(pt_rdata[PW-1:CB]) < $signed(pa_r[PW-1:CB])) ||
                    ((pt_rdata[PW-1:CB] == pa_r[PW-1:CB]) &&
                     ($signed(pt_rdata[CB-1:0]) < $signed(pa_r[CB-1:0])));
  assign sum_ext  = SUMW'(sum_r) + SUMW'(sq_root);
  assign sq_start = (cmd.op == OP_SQ_START);
  assign mul_p    = mul_a * mul_b;

  chp_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  chp_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  chp_isqrt #(.VW(VW)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (VW'(dd_r) << (2 * FRAC_BITS)),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = n_r[AW-1:0];
    pt_wdata = {in_y, in_x};
    pt_raddr = i_r[AW-1:0];
    st_we    = 1'b0;
    st_waddr = sd_r[AW-1:0];
    st_wdata = pc_r;
    st_raddr = k_r[AW-1:0];
    mul_a    = ux_r;
    mul_b    = vy_r;
    case (cmd.op)
      OP_STORE: begin
        pt_we = has_room;
      end
      OP_RD0: begin
        pt_raddr = '0;
      end
      OP_RD_PREV: begin
        pt_raddr = jm1[AW-1:0];
      end
      OP_SWAP_A: begin
        pt_we    = 1'b1;
        pt_waddr = lo_r;
        pt_wdata = pt_rdata;
      end
      OP_SWAP_B: begin
        pt_we    = 1'b1;
        pt_waddr = '0;
        pt_wdata = pa_r;
      end
      OP_SHIFT: begin
        pt_we    = 1'b1;
        pt_waddr = j_r[AW-1:0];
        pt_wdata = pc_r;
      end
      OP_INSERT: begin
        pt_we    = 1'b1;
        pt_waddr = j_r[AW-1:0];
        pt_wdata = pb_r;
      end
      OP_PUSH: begin
        st_we = 1'b1;
      end
      OP_POP: begin
        st_raddr = dm3[AW-1:0];
      end
      OP_P_INIT: begin
        st_raddr = '0;
      end
      OP_T_M2: begin
        mul_a = uy_r;
        mul_b = vx_r;
      end
      OP_D_M1: begin
        mul_a = ux_r;
        mul_b = ux_r;
      end
      OP_D_M2: begin
        mul_a = uy_r;
        mul_b = uy_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= '0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      sd_r      <= '0;
      sum_r     <= '0;
      dropped_r <= 1'b0;
      small_r   <= 1'b0;
    end else begin
      case (cmd.op)
        OP_STORE: begin
          if (has_room) begin
            n_r <= n_nxt;
          end else begin
            dropped_r <= 1'b1;
          end
          if (in_last) begin
            i_r     <= '0;
            small_r <= few;
            sum_r   <= '0;
            sd_r    <= '0;
          end
        end
        OP_CLEAR: begin
          n_r       <= '0;
          dropped_r <= 1'b0;
          small_r   <= 1'b0;
        end
        OP_MIN_CMP: begin
          if ((i_r == '0) || lower) begin
            pa_r <= pt_rdata;
            lo_r <= i_r[AW-1:0];
          end
          i_r <= i_r + CW'(1);
        end
        OP_SWAP_B: begin
          i_r <= CW'(2);
        end
        OP_RD_I: begin
          j_r <= i_r;
        end
        OP_KEY: begin
          pb_r <= pt_rdata;
        end
        OP_PREV: begin
          pc_r <= pt_rdata;
        end
        OP_T_DIFF: begin
          ux_r <= sub_c(pb_r[CB-1:0], pa_r[CB-1:0]);
          uy_r <= sub_c(pb_r[PW-1:CB], pa_r[PW-1:CB]);
          vx_r <= sub_c(pc_r[CB-1:0], pb_r[CB-1:0]);
          vy_r <= sub_c(pc_r[PW-1:CB], pb_r[PW-1:CB]);
        end
        OP_T_M1, OP_D_M1: begin
          p1_r <= mul_p;
        end
        OP_T_M2, OP_D_M2: begin
          p2_r <= mul_p;
        end
        OP_T_X: begin
          cr_r <= $signed({p1_r[PRW-1], p1_r}) - $signed({p2_r[PRW-1], p2_r});
        end
        OP_D_DIFF_B: begin
          ux_r <= sub_c(pa_r[CB-1:0], pb_r[CB-1:0]);
          uy_r <= sub_c(pa_r[PW-1:CB], pb_r[PW-1:CB]);
        end
        OP_D_DIFF_C: begin
          ux_r <= sub_c(pa_r[CB-1:0], pc_r[CB-1:0]);
          uy_r <= sub_c(pa_r[PW-1:CB], pc_r[PW-1:CB]);
        end
        OP_D_SUM: begin
          dd0_r <= dd_r;
          dd_r  <= $unsigned(p1_r) + $unsigned(p2_r);
        end
        OP_SHIFT: begin
          j_r <= jm1;
        end
        OP_INSERT: begin
          i_r <= i_r + CW'(1);
        end
        OP_SCAN_INIT: begin
          i_r  <= '0;
          sd_r <= '0;
        end
        OP_SCAN_GOT: begin
          pc_r <= pt_rdata;
        end
        OP_SCAN_LD: begin
          pa_r <= s_r;
          pb_r <= t_r;
        end
        OP_PUSH: begin
          sd_r <= sd_r + CW'(1);
          s_r  <= t_r;
          t_r  <= pc_r;
          i_r  <= i_r + CW'(1);
        end
        OP_POP: begin
          sd_r <= sd_r - CW'(1);
          t_r  <= s_r;
        end
        OP_POP_GOT: begin
          // new second entry only exists while two or more remain
          if (sd_r > CW'(1)) begin
            s_r <= st_rdata;
          end
        end
        OP_P_INIT: begin
          k_r   <= CW'(1);
          sum_r <= '0;
        end
        OP_P_FIRST: begin
          f_r  <= st_rdata;
          pa_r <= st_rdata;
        end
        OP_P_GOT: begin
          pb_r <= st_rdata;
        end
        OP_P_CLOSE: begin
          pb_r <= f_r;
        end
        OP_ACC: begin
          sum_r <= (sum_ext > SUMW'(PERIM_MAX)) ? PERIM_MAX : sum_ext[PERIM_W-1:0];
          pa_r  <= pb_r;
          k_r   <= k_r + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sts.few         = few;
    sts.min_last    = ((i_r + CW'(1)) == n_r);
    sts.i_end       = (i_r == n_r);
    sts.i_lt3       = (i_r < CW'(3));
    sts.j_gt1       = (j_r > CW'(1));
    sts.d_gt1       = (sd_r > CW'(1));
    sts.k_eq_d      = (k_r == sd_r);
    sts.cross_zero  = (cr_r == '0);
    sts.cross_neg   = cr_r[CRW-1];
    sts.dist_before = (dd0_r > dd_r);
    sts.sq_busy     = sq_busy;
  end

  assign perimeter = sum_r;
  assign hull_size = HULL_W'(sd_r);
  assign status    = small_r ? ST_FEW : (dropped_r ? ST_DROP : ST_OK);

endmodule

[design/chp_ctrl.sv]
// ----------------------------------------------------------------------------
// chp_ctrl - hull controller
// Sequences load, lowest-point sweep, insertion sort by angle, stack scan,
// perimeter walk and result handoff.
// ----------------------------------------------------------------------------
module chp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  chp_pkg::sts_t sts,
  output chp_pkg::cmd_t cmd
);

  import chp_pkg::*;

  typedef enum logic [30:0] {
    S_LOAD      = 31'h1 << 0,
    S_MIN_RD    = 31'h1 << 1,
    S_MIN_CMP   = 31'h1 << 2,
    S_RD0       = 31'h1 << 3,
    S_SWAP_A    = 31'h1 << 4,
    S_SWAP_B    = 31'h1 << 5,
    S_SORT_TOP  = 31'h1 << 6,
    S_SORT_KEY  = 31'h1 << 7,
    S_SORT_CHK  = 31'h1 << 8,
    S_SORT_PREV = 31'h1 << 9,
    S_T_DIFF    = 31'h1 << 10,
    S_T_M1      = 31'h1 << 11,
    S_T_M2      = 31'h1 << 12,
    S_T_X       = 31'h1 << 13,
    S_TURN_DEC  = 31'h1 << 14,
    S_D_DIFF_B  = 31'h1 << 15,
    S_D_DIFF_C  = 31'h1 << 16,
    S_D_M1      = 31'h1 << 17,
    S_D_M2      = 31'h1 << 18,
    S_D_SUM     = 31'h1 << 19,
    S_SORT_CMPD = 31'h1 << 20,
    S_SCAN_TOP  = 31'h1 << 21,
    S_SCAN_GOT  = 31'h1 << 22,
    S_SCAN_CHK  = 31'h1 << 23,
    S_POP_GOT   = 31'h1 << 24,
    S_P_FIRST   = 31'h1 << 25,
    S_P_TOP     = 31'h1 << 26,
    S_P_GOT     = 31'h1 << 27,
    S_SQ_START  = 31'h1 << 28,
    S_SQ_WAIT   = 31'h1 << 29,
    S_RES       = 31'h1 << 30
  } state_t;

  state_t state_r, state_nxt;
  logic   scan_r, scan_nxt;
  logic   perim_r, perim_nxt;
  logic   second_r, second_nxt;
  logic   ccw;

  assign ccw        = !sts.cross_zero && !sts.cross_neg;
  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_RES);

  always_comb begin
    state_nxt  = state_r;
    scan_nxt   = scan_r;
    perim_nxt  = perim_r;
    second_nxt = second_r;
    cmd.op     = OP_NOP;
    case (state_r)
      S_LOAD: begin
        scan_nxt  = 1'b0;
        perim_nxt = 1'b0;
        if (in_tvalid) begin
          cmd.op = OP_STORE;
          if (in_tlast) begin
            state_nxt = sts.few ? S_RES : S_MIN_RD;
          end
        end
      end
      S_MIN_RD: begin
        cmd.op    = OP_MIN_RD;
        state_nxt = S_MIN_CMP;
      end
      S_MIN_CMP: begin
        cmd.op    = OP_MIN_CMP;
        state_nxt = sts.min_last ? S_RD0 : S_MIN_RD;
      end
      S_RD0: begin
        cmd.op    = OP_RD0;
        state_nxt = S_SWAP_A;
      end
      S_SWAP_A: begin
        cmd.op    = OP_SWAP_A;
        state_nxt = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.op    = OP_SWAP_B;
        state_nxt = S_SORT_TOP;
      end
      S_SORT_TOP: begin
        if (sts.i_end) begin
          cmd.op    = OP_SCAN_INIT;
          scan_nxt  = 1'b1;
          state_nxt = S_SCAN_TOP;
        end else begin
          cmd.op    = OP_RD_I;
          state_nxt = S_SORT_KEY;
        end
      end
      S_SORT_KEY: begin
        cmd.op    = OP_KEY;
        state_nxt = S_SORT_CHK;
      end
      S_SORT_CHK: begin
        if (sts.j_gt1) begin
          cmd.op    = OP_RD_PREV;
          state_nxt = S_SORT_PREV;
        end else begin
          cmd.op    = OP_INSERT;
          state_nxt = S_SORT_TOP;
        end
      end
      S_SORT_PREV: begin
        cmd.op    = OP_PREV;
        state_nxt = S_T_DIFF;
      end
      S_T_DIFF: begin
        cmd.op    = OP_T_DIFF;
        state_nxt = S_T_M1;
      end
      S_T_M1: begin
        cmd.op    = OP_T_M1;
        state_nxt = S_T_M2;
      end
      S_T_M2: begin
        cmd.op    = OP_T_M2;
        state_nxt = S_T_X;
      end
      S_T_X: begin
        cmd.op    = OP_T_X;
        state_nxt = S_TURN_DEC;
      end
      S_TURN_DEC: begin
        if (scan_r) begin
          if (ccw) begin
            cmd.op    = OP_PUSH;
            state_nxt = S_SCAN_TOP;
          end else begin
            cmd.op    = OP_POP;
            state_nxt = S_POP_GOT;
          end
        end else if (ccw) begin
          cmd.op    = OP_SHIFT;
          state_nxt = S_SORT_CHK;
        end else if (sts.cross_neg) begin
          cmd.op    = OP_INSERT;
          state_nxt = S_SORT_TOP;
        end else begin
          // collinear with origin: order by distance
          state_nxt = S_D_DIFF_C;
        end
      end
      S_D_DIFF_C: begin
        cmd.op     = OP_D_DIFF_C;
        second_nxt = 1'b0;
        state_nxt  = S_D_M1;
      end
      S_D_DIFF_B: begin
        cmd.op     = OP_D_DIFF_B;
        second_nxt = 1'b1;
        state_nxt  = S_D_M1;
      end
      S_D_M1: begin
        cmd.op    = OP_D_M1;
        state_nxt = S_D_M2;
      end
      S_D_M2: begin
        cmd.op    = OP_D_M2;
        state_nxt = S_D_SUM;
      end
      S_D_SUM: begin
        cmd.op = OP_D_SUM;
        if (perim_r) begin
          state_nxt = S_SQ_START;
        end else if (second_r) begin
          state_nxt = S_SORT_CMPD;
        end else begin
          state_nxt = S_D_DIFF_B;
        end
      end
      S_SORT_CMPD: begin
        if (sts.dist_before) begin
          cmd.op    = OP_SHIFT;
          state_nxt = S_SORT_CHK;
        end else begin
          cmd.op    = OP_INSERT;
          state_nxt = S_SORT_TOP;
        end
      end
      S_SCAN_TOP: begin
        if (sts.i_end) begin
          cmd.op    = OP_P_INIT;
          perim_nxt = 1'b1;
          state_nxt = S_P_FIRST;
        end else begin
          cmd.op    = OP_RD_I;
          state_nxt = S_SCAN_GOT;
        end
      end
      S_SCAN_GOT: begin
        cmd.op    = OP_SCAN_GOT;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.i_lt3 || !sts.d_gt1) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_SCAN_TOP;
        end else begin
          cmd.op    = OP_SCAN_LD;
          state_nxt = S_T_DIFF;
        end
      end
      S_POP_GOT: begin
        cmd.op    = OP_POP_GOT;
        state_nxt = S_SCAN_CHK;
      end
      S_P_FIRST: begin
        cmd.op    = OP_P_FIRST;
        state_nxt = S_P_TOP;
      end
      S_P_TOP: begin
        if (sts.k_eq_d) begin
          cmd.op    = OP_P_CLOSE;
          state_nxt = S_D_DIFF_B;
        end else begin
          cmd.op    = OP_P_RD;
          state_nxt = S_P_GOT;
        end
      end
      S_P_GOT: begin
        cmd.op    = OP_P_GOT;
        state_nxt = S_D_DIFF_B;
      end
      S_SQ_START: begin
        cmd.op    = OP_SQ_START;
        state_nxt = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (!sts.sq_busy) begin
          cmd.op    = OP_ACC;
          state_nxt = sts.k_eq_d ? S_RES : S_P_TOP;
        end
      end
      S_RES: begin
        if (out_tready) begin
          cmd.op    = OP_CLEAR;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      scan_r   <= 1'b0;
      perim_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      scan_r   <= scan_nxt;
      perim_r  <= perim_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

[design/convex_hull_perimeter_top.sv]
// ----------------------------------------------------------------------------
// convex_hull_perimeter_top - Graham scan hull perimeter
// Collects a point set, builds its convex hull and reports the perimeter.
//
//   channel  dir  payload                                   request ends on
//   in_*     in   tdata {y, x}, tlast = last point          tlast = 1
//   out_*    out  tdata {hull_size, perimeter}, tuser status one per set
//
// points load at one per cycle; after the last point the block is busy
// with the minimum search, the sort compares (O(n^2) worst case), the
// scan turns and, for each hull edge, mostly the serial square root.
// sets of fewer than three points answer the cycle after the last point.
// reset is synchronous; no memory clearing pass is needed.
// in_tready stays low from the last point until the result is taken.
// ----------------------------------------------------------------------------
module convex_hull_perimeter_top #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]        in_tdata,  // point_x, point_y
  input  logic                                     in_tlast,  // last_point
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [chp_pkg::OUT_TDATA_W-1:0]          out_tdata, // perimeter, hull_size
  output logic [chp_pkg::STAT_W-1:0]               out_tuser  // status
);

  import chp_pkg::*;

  cmd_t                 cmd;
  sts_t                 sts;
  logic [PERIM_W-1:0]   perimeter;
  logic [HULL_W-1:0]    hull_size;

  chp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  chp_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_x      (in_tdata[COORD_BITS-1:0]),
    .in_y      (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_last   (in_tlast),
    .sts       (sts),
    .perimeter (perimeter),
    .hull_size (hull_size),
    .status    (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'({hull_size, perimeter});

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - convex hull perimeter block
// Streams point sets into the block and checks every perimeter result
// against a predictor kept in the bench: Graham scan over exact integer
// cross products, with a floor square root per edge. Both stream sides
// stall at random in bursts, except during the final stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import chp_pkg::*;

  localparam int CAP       = 1024;
  localparam int CBITS     = 24;
  localparam int FBITS     = 16;
  localparam int IN_W      = ((2*CBITS+7)/8)*8;
  localparam int WDOG_MAX  = 400000;
  localparam int CMIN      = -(1 << (CBITS-1));
  localparam int CMAX      = (1 << (CBITS-1)) - 1;

  typedef struct {
    logic [PERIM_W-1:0] perim;
    logic [HULL_W-1:0]  hsize;
    logic [STAT_W-1:0]  stat;
  } hull_res_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0] out_tuser;

  hull_res_t pending_hulls[$];
  longint    px[CAP];
  longint    py[CAP];
  int        n_pts;
  bit        overflowed;
  int        stack_idx[CAP];
  int        n_sets, n_points, n_seen, n_errors, idle_cycles;
  bit        calm;
  int        stall_left;

  convex_hull_perimeter_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- predictor ----------------
  // cross sign of a -> b -> c: 0 collinear, 1 clockwise, 2 counterclockwise
  function automatic int orient(int a, int b, int c);
    longint d;
    d = (px[b]-px[a])*(py[c]-py[b]) - (py[b]-py[a])*(px[c]-px[b]);
    if (d == 0) return 0;
    return (d < 0) ? 1 : 2;
  endfunction

  function automatic longint sq_dist(int a, int b);
    longint dx, dy;
    dx = px[a] - px[b];
    dy = py[a] - py[b];
    return dx*dx + dy*dy;
  endfunction

  function automatic bit sorts_ahead(int a, int b);
    int t;
    t = orient(0, a, b);
    if (t == 0) return sq_dist(0, b) > sq_dist(0, a);
    return t == 2;
  endfunction

  function automatic void swap_pts(int i, int j);
    longint tx, ty;
    tx = px[i]; ty = py[i];
    px[i] = px[j]; py[i] = py[j];
    px[j] = tx; py[j] = ty;
  endfunction

  function automatic logic [63:0] edge_root(int a, int b);
    logic [127:0] v, t;
    logic [63:0]  r;
    v = {64'd0, sq_dist(a, b)} << (2*FBITS);
    r = '0;
    for (int bt = 62; bt >= 0; bt--) begin
      t = {64'd0, r | (64'd1 << bt)};
      if (t*t <= v) r = t[63:0];
    end
    return r;
  endfunction

  function automatic hull_res_t hull_perimeter();
    hull_res_t res;
    int lo, j, depth, nx;
    logic [63:0] sum;
    if (n_pts < 3) begin
      res.perim = '0; res.hsize = '0; res.stat = ST_FEW;
      return res;
    end
    lo = 0;
    for (int i = 1; i < n_pts; i++)
      if (py[i] < py[lo] || (py[i] == py[lo] && px[i] < px[lo])) lo = i;
    swap_pts(0, lo);
    for (int i = 2; i < n_pts; i++) begin
      j = i;
      while (j > 1 && sorts_ahead(j, j-1)) begin
        swap_pts(j, j-1);
        j--;
      end
    end
    stack_idx[0] = 0; stack_idx[1] = 1; stack_idx[2] = 2;
    depth = 3;
    for (int i = 3; i < n_pts; i++) begin
      while (depth > 1 && orient(stack_idx[depth-2], stack_idx[depth-1], i) != 2) depth--;
      stack_idx[depth] = i;
      depth++;
    end
    sum = '0;
    for (int k = 0; k < depth; k++) begin
      nx = (k+1 < depth) ? k+1 : 0;
      sum = sum + edge_root(stack_idx[k], stack_idx[nx]);
      if (sum > {22'd0, PERIM_MAX}) sum = {22'd0, PERIM_MAX};
    end
    res.perim = sum[PERIM_W-1:0];
    res.hsize = depth[HULL_W-1:0];
    res.stat  = overflowed ? ST_DROP : ST_OK;
    return res;
  endfunction

  function automatic void take_point(logic [CBITS-1:0] x, logic [CBITS-1:0] y, bit last);
    if (n_pts < CAP) begin
      px[n_pts] = longint'($signed(x));
      py[n_pts] = longint'($signed(y));
      n_pts++;
    end else begin
      overflowed = 1'b1;
    end
    n_points++;
    if (last) begin
      pending_hulls.insert(pending_hulls.size(), hull_perimeter());
      n_pts = 0;
      overflowed = 1'b0;
      n_sets++;
    end
  endfunction

  // ---------------- stimulus ----------------
  task automatic send_point(int x, int y, bit last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y[CBITS-1:0], x[CBITS-1:0]};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    take_point(x[CBITS-1:0], y[CBITS-1:0], last);
  endtask

  function automatic int rand_coord(int mode);
    case (mode)
      0: return int'($urandom_range(0, 1)) ? CMAX - int'($urandom_range(0, 3))
                                            : CMIN + int'($urandom_range(0, 3));
      1: return int'($urandom_range(0, 16)) - 8;
      default: return int'($urandom_range(0, (1 << CBITS) - 1)) + CMIN;
    endcase
  endfunction

  task automatic send_random_set(int n);
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_point(rand_coord(mode), rand_coord(mode), i == n-1);
  endtask

  task automatic test_short_sets();
    send_point(5, -7, 1'b1);
    send_point(CMIN, CMAX, 1'b0);
    send_point(CMAX, CMIN, 1'b1);
  endtask

  task automatic test_extremes();
    // full-range square, points given in scrambled order
    send_point(CMAX, CMAX, 1'b0);
    send_point(CMIN, CMIN, 1'b0);
    send_point(CMIN, CMAX, 1'b0);
    send_point(CMAX, CMIN, 1'b1);
    // equal lowest y, leftmost must win
    send_point(3, -100, 1'b0);
    send_point(-3, -100, 1'b0);
    send_point(0, 50, 1'b1);
  endtask

  task automatic test_degenerate();
    // collinear, duplicated and collinear-with-interior points
    send_point(0, 0, 1'b0);
    send_point(2, 2, 1'b0);
    send_point(1, 1, 1'b1);
    send_point(7, 7, 1'b0);
    send_point(7, 7, 1'b0);
    send_point(7, 7, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(4, 0, 1'b0);
    send_point(2, 0, 1'b0);
    send_point(4, 4, 1'b0);
    send_point(0, 4, 1'b0);
    send_point(2, 2, 1'b1);
  endtask

  task automatic test_long_set();
    // long collinear run already in angle order so the sort stays linear
    for (int i = 0; i < 120; i++) send_point(i, i, i == 119);
    send_random_set(5);
  endtask

  task automatic test_random();
    for (int s = 0; s < 72; s++) begin
      if (s == 60) calm = 1'b1;
      if ($urandom_range(0, 15) == 0) send_random_set($urandom_range(20, 40));
      else send_random_set($urandom_range(1, 10));
    end
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hull_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      n_seen++;
      if (pending_hulls.size() == 0) begin
        $error("result with nothing expected: tdata %h tuser %0d", out_tdata, out_tuser);
        n_errors++;
      end else begin
        exp_r = pending_hulls.pop_front();
        if (out_tdata[PERIM_W-1:0] !== exp_r.perim) begin
          $error("perimeter: expected %0d actual %0d", exp_r.perim, out_tdata[PERIM_W-1:0]);
          n_errors++;
        end
        if (out_tdata[PERIM_W +: HULL_W] !== exp_r.hsize) begin
          $error("hull_size: expected %0d actual %0d", exp_r.hsize,
                 out_tdata[PERIM_W +: HULL_W]);
          n_errors++;
        end
        if (out_tuser !== exp_r.stat) begin
          $error("status: expected %0d actual %0d", exp_r.stat, out_tuser);
          n_errors++;
        end
      end
    end
  end

  // no request moving on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog expired with %0d results outstanding", pending_hulls.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    calm = 1'b0;
    n_pts = 0;
    overflowed = 1'b0;
    n_sets = 0; n_points = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_sets();
    test_extremes();
    test_degenerate();
    test_long_set();
    test_random();
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (pending_hulls.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d point sets from %0d points, %0d results checked", n_sets,
             n_points, n_seen);
    $display("sets ranged from single points to a 120-point collinear run, with full-range");
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
